/* sv/grid_majority_filter_signature_assert.svh */
// Assertion macros for the grid majority filter signature block.
// Each macro takes a label, the clock, the active-low reset and the checked terms.
`ifndef GRID_MAJORITY_FILTER_SIGNATURE_ASSERT_SVH
`define GRID_MAJORITY_FILTER_SIGNATURE_ASSERT_SVH

// The condition must never hold at a clock edge outside reset.
`define GMFS_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error(msg);

// When the antecedent holds, the consequent holds at the same edge.
`define GMFS_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds at the following edge.
`define GMFS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/gmfs_pkg.sv */
// Shared types and constants for the grid majority filter signature block.
// No dependencies; every module in the project imports this package.
`timescale 1ns / 1ps
`default_nettype none

package gmfs_pkg;

    localparam int GRID_W     = 16;
    localparam int GRID_H     = 12;
    localparam int CELL_COUNT = GRID_W * GRID_H;
    localparam int SLOT_COUNT = 3;

    localparam int COL_W  = (GRID_W > 1) ? $clog2(GRID_W) : 1;
    localparam int ROW_W  = (GRID_H > 1) ? $clog2(GRID_H) : 1;
    localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int SLOT_W = 2;
    localparam int SEEN_W = 2;

    localparam logic [31:0] HASH_BASIS = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME = 32'd16777619;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_IDX_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STABLE_THRESHOLD = 2'd0,
        CFG_MARKER_CODE      = 2'd1,
        CFG_EMPTY_CODE       = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] stable_threshold;
        logic [7:0] marker_code;
        logic [7:0] empty_code;
    } cfg_t;

    typedef struct packed {
        logic [7:0] cell_in;
        logic [7:0] marker_col;
        logic [7:0] marker_row;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  filtered_cell;
        logic        frame_last;
        logic [31:0] signature;
        logic [15:0] stable_count;
        logic        sig_changed;
        logic        stable_reached;
        logic        plan_request;
    } out_item_t;

    // Per-cell result handed from the cell path to the frame tracker.
    typedef struct packed {
        logic        valid;
        logic [7:0]  filtered;
        logic        last;
        logic [31:0] sig;
    } cell_res_t;

endpackage

`default_nettype wire

/* sv/grid_majority_filter_signature.sv */
// Channel  | Handshake          | Payload
// s_       | s_valid / s_ready  | s_data (in_item_t): raw cell, marker column and row
// m_       | m_valid / m_ready  | m_data (out_item_t): filtered cell and frame report
// cfg_     | cfg_we             | cfg_addr (register index), cfg_wdata
//
// One cell transaction per cycle while the queue has room; each result is registered
// after the history read and after the vote plus hash step, then gets its frame report.
// The history memory needs no clearing pass; reset clears counters and frame state.
// A four-entry output queue absorbs consumer stalls; s_ready drops once the queue
// plus the two pipeline stages hold four transactions.
// Top level. Depends on gmfs_pkg, gmfs_cell_path, gmfs_frame_track, gmfs_out_fifo
// and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "grid_majority_filter_signature_assert.svh"

module grid_majority_filter_signature
    import gmfs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_item_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_item_t                 m_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [7:0]           cfg_wdata
);

    cfg_t                  cfg_reg, cfg_next;
    logic                  accept;
    logic                  vote_busy;
    cell_res_t             cell_res;
    logic                  push;
    out_item_t             push_item;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W-1:0] in_flight;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_STABLE_THRESHOLD: cfg_next.stable_threshold = cfg_wdata;
                CFG_MARKER_CODE:      cfg_next.marker_code      = cfg_wdata;
                CFG_EMPTY_CODE:       cfg_next.empty_code       = cfg_wdata;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stable_threshold <= 8'd3;
            cfg_reg.marker_code      <= 8'd64;
            cfg_reg.empty_code       <= 8'd45;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Admit a transaction only while the queue can take everything in flight.
    assign in_flight = fifo_count + FIFO_CNT_W'(vote_busy) + FIFO_CNT_W'(cell_res.valid);
    assign s_ready   = (in_flight < FIFO_CNT_W'(FIFO_DEPTH));
    assign accept    = s_valid && s_ready;

    gmfs_cell_path u_cell_path (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_item   (s_data),
        .cfg       (cfg_reg),
        .vote_busy (vote_busy),
        .res       (cell_res)
    );

    gmfs_frame_track u_frame_track (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .res              (cell_res),
        .stable_threshold (cfg_reg.stable_threshold),
        .push             (push),
        .item             (push_item)
    );

    gmfs_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .count     (fifo_count)
    );

    `GMFS_ASSERT_NEVER(a_no_overflow, aclk, aresetn, push && (fifo_count == FIFO_CNT_W'(FIFO_DEPTH)) && !m_ready, "output queue overflow")
    `GMFS_ASSERT_NEXT(a_accept_to_vote, aclk, aresetn, accept, vote_busy, "accepted cell did not reach vote stage")
    `GMFS_ASSERT_IMPLY(a_request_stable, aclk, aresetn, m_valid && m_data.plan_request, m_data.stable_reached && m_data.frame_last, "plan request without stable frame end")

endmodule

`default_nettype wire

/* sv/gmfs_hist_mem.sv */
// History memory: one 24-bit entry per cell, three byte lanes (one per frame slot).
// Registered synchronous read, per-lane write enable. Uses gmfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gmfs_hist_mem
    import gmfs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic [ADDR_W-1:0]     addr,
    input  wire logic [SLOT_COUNT-1:0] lane_we,
    input  wire logic [7:0]            wdata,
    output logic [8*SLOT_COUNT-1:0]    rdata
);

    logic [8*SLOT_COUNT-1:0] mem [CELL_COUNT];

    // Read returns the entry as it was before this cycle's write.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (lane_we[i]) begin
                    mem[addr][i*8 +: 8] <= wdata;
                end
            end
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

/* sv/gmfs_cell_path.sv */
// Cell path: position counters, marker clean-up, history read-modify-write,
// majority vote and FNV-1a hash step. Uses gmfs_pkg and gmfs_hist_mem.
`timescale 1ns / 1ps
`default_nettype none

module gmfs_cell_path
    import gmfs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     accept,
    input  wire in_item_t in_item,
    input  wire cfg_t     cfg,
    output logic          vote_busy,
    output cell_res_t     res
);

    // stage 0 counters
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;

    // stage 1
    logic              s1_valid_reg;
    logic [7:0]        s1_cell_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic              s1_vote_reg;
    logic              s1_last_reg;
    logic [31:0]       hash_reg, hash_next;

    // stage 2 output
    cell_res_t         res_reg;

    logic [7:0]              clean_cell;
    logic                    marker_hit;
    logic                    last0;
    logic [SLOT_COUNT-1:0]   lane_we;
    logic [8*SLOT_COUNT-1:0] rdata;
    logic [7:0]              slot_byte [SLOT_COUNT];
    logic [7:0]              filtered;
    logic [31:0]             hash_mix;
    logic [31:0]             hash_prod;

    always_comb begin
        marker_hit = (in_item.marker_col < 8'(GRID_W)) && (in_item.marker_row < 8'(GRID_H))
                     && (in_item.marker_col == 8'(col_reg))
                     && (in_item.marker_row == 8'(row_reg));
        clean_cell = (in_item.cell_in == cfg.marker_code) ? cfg.empty_code : in_item.cell_in;
        if (marker_hit) begin
            clean_cell = cfg.marker_code;
        end
        last0 = (row_reg == ROW_W'(GRID_H - 1)) && (col_reg == COL_W'(GRID_W - 1));
    end

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        addr_next = addr_reg;
        slot_next = slot_reg;
        seen_next = seen_reg;
        if (accept) begin
            if (last0) begin
                col_next  = '0;
                row_next  = '0;
                addr_next = '0;
                slot_next = (slot_reg == SLOT_W'(SLOT_COUNT - 1)) ? '0 : slot_reg + 1'b1;
                if (seen_reg < SEEN_W'(SLOT_COUNT)) begin
                    seen_next = seen_reg + 1'b1;
                end
            end else begin
                addr_next = addr_reg + 1'b1;
                if (col_reg == COL_W'(GRID_W - 1)) begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            addr_reg <= '0;
            slot_reg <= '0;
            seen_reg <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            addr_reg <= addr_next;
            slot_reg <= slot_next;
            seen_reg <= seen_next;
        end
    end

    // Write the new byte and read the entry in the same cycle; the stale lane is
    // patched in stage 1. A lane is only voted on once a full frame has filled it,
    // so entries never written since reset do not reach the output.
    assign lane_we = accept ? (SLOT_COUNT'(1) << slot_reg) : '0;

    gmfs_hist_mem u_hist_mem (
        .aclk    (aclk),
        .en      (accept),
        .addr    (addr_reg),
        .lane_we (lane_we),
        .wdata   (clean_cell),
        .rdata   (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cell_reg <= clean_cell;
            s1_slot_reg <= slot_reg;
            s1_vote_reg <= (seen_reg >= SEEN_W'(SLOT_COUNT - 1));
            s1_last_reg <= last0;
        end
    end

    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_byte[i] = (s1_slot_reg == SLOT_W'(i)) ? s1_cell_reg : rdata[i*8 +: 8];
        end
        if (!s1_vote_reg) begin
            filtered = s1_cell_reg;
        end else if ((slot_byte[0] == slot_byte[1]) || (slot_byte[0] == slot_byte[2])) begin
            filtered = slot_byte[0];
        end else if (slot_byte[1] == slot_byte[2]) begin
            filtered = slot_byte[1];
        end else begin
            filtered = s1_cell_reg;
        end
        hash_mix  = hash_reg ^ {24'd0, filtered};
        hash_prod = 32'(hash_mix * HASH_PRIME);
        hash_next = hash_reg;
        if (s1_valid_reg) begin
            hash_next = s1_last_reg ? HASH_BASIS : hash_prod;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg      <= HASH_BASIS;
            res_reg.valid <= 1'b0;
        end else begin
            hash_reg      <= hash_next;
            res_reg.valid <= s1_valid_reg;
        end
        if (s1_valid_reg) begin
            res_reg.filtered <= filtered;
            res_reg.last     <= s1_last_reg;
            res_reg.sig      <= hash_prod;
        end
    end

    assign vote_busy = s1_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

/* sv/gmfs_frame_track.sv */
// Frame tracker: repeat count, change flag, stable flag and one-shot plan request
// at each frame end. Uses gmfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gmfs_frame_track
    import gmfs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cell_res_t res,
    input  wire logic [7:0] stable_threshold,
    output logic           push,
    output out_item_t      item
);

    logic [31:0] last_sig_reg, last_sig_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] req_sig_reg, req_sig_next;
    logic        req_valid_reg, req_valid_next;

    logic        frame_end;
    logic        same;
    logic [15:0] count_new;
    logic        reached;
    logic        request;

    always_comb begin
        frame_end = res.valid && res.last;
        same      = (res.sig == last_sig_reg);
        if (!same) begin
            count_new = 16'd1;
        end else if (count_reg == COUNT_MAX) begin
            count_new = count_reg;
        end else begin
            count_new = count_reg + 16'd1;
        end
        reached = (count_new >= {8'd0, stable_threshold});
        request = reached && (!req_valid_reg || (res.sig != req_sig_reg));

        last_sig_next  = last_sig_reg;
        count_next     = count_reg;
        req_sig_next   = req_sig_reg;
        req_valid_next = req_valid_reg;
        if (frame_end) begin
            last_sig_next = res.sig;
            count_next    = count_new;
            if (request) begin
                req_sig_next   = res.sig;
                req_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_sig_reg  <= '0;
            count_reg     <= '0;
            req_sig_reg   <= '0;
            req_valid_reg <= 1'b0;
        end else begin
            last_sig_reg  <= last_sig_next;
            count_reg     <= count_next;
            req_sig_reg   <= req_sig_next;
            req_valid_reg <= req_valid_next;
        end
    end

    // Frame fields read as zero off the last cell.
    always_comb begin
        push                = res.valid;
        item.filtered_cell  = res.filtered;
        item.frame_last     = res.last;
        item.signature      = res.last ? res.sig : '0;
        item.stable_count   = res.last ? count_new : '0;
        item.sig_changed    = res.last && !same;
        item.stable_reached = res.last && reached;
        item.plan_request   = res.last && request;
    end

endmodule

`default_nettype wire

/* sv/gmfs_out_fifo.sv */
// Output queue: holds finished result transactions while the consumer stalls.
// Uses gmfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gmfs_out_fifo
    import gmfs_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire out_item_t       push_item,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output out_item_t            m_data,
    output logic [FIFO_CNT_W-1:0] count
);

    out_item_t               entry [FIFO_DEPTH];
    logic [FIFO_IDX_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_IDX_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;
    logic                    pop;

    always_comb begin
        pop         = (count_reg != '0) && m_ready;
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry[wr_ptr_reg] <= push_item;
        end
    end

    assign m_valid = (count_reg != '0);
    assign m_data  = entry[rd_ptr_reg];
    assign count   = count_reg;

endmodule

`default_nettype wire

/* verif/gmfs_frame_checker.sv */
// Result checker for the grid majority filter: predicts each result from the accepted
// cell transactions and register writes, then compares the results field by field.
// Depends on gmfs_pkg.
`timescale 1ns / 1ps

module gmfs_frame_checker
    import gmfs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  in_item_t             s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  out_item_t            m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [7:0]           cfg_wdata,
    output int                   mismatches,
    output int                   pending
);

    logic [7:0]  history [CELL_COUNT][SLOT_COUNT];
    int unsigned slot_idx;
    int unsigned frames_seen;
    int unsigned cur_row;
    int unsigned cur_col;
    logic [31:0] run_hash;
    logic [31:0] prev_sig;
    logic [31:0] requested_sig;
    logic [15:0] repeat_count;
    logic        requested;
    cfg_t        regs;

    out_item_t   expected_cells [$];
    int          fail_count = 0;
    int          queued = 0;

    assign mismatches = fail_count;
    assign pending    = queued;

    // Advance the filter state by one cell and return the result it produces.
    function automatic out_item_t filter_cell(input in_item_t item);
        logic [7:0]  cell_byte;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  filt;
        int unsigned pos;
        out_item_t   res;

        cell_byte = item.cell_in;
        pos  = cur_row * GRID_W + cur_col;
        if (cell_byte == regs.marker_code) begin
            cell_byte = regs.empty_code;
        end
        if (item.marker_col < GRID_W && item.marker_row < GRID_H &&
            item.marker_col == cur_col && item.marker_row == cur_row) begin
            cell_byte = regs.marker_code;
        end
        history[pos][slot_idx] = cell_byte;

        filt = cell_byte;
        if (frames_seen >= SLOT_COUNT - 1) begin
            a = history[pos][0];
            b = history[pos][1];
            c = history[pos][2];
            if (a == b || a == c) begin
                filt = a;
            end else if (b == c) begin
                filt = b;
            end
        end
        run_hash = (run_hash ^ {24'd0, filt}) * HASH_PRIME;

        res = '0;
        res.filtered_cell = filt;
        if (cur_row == GRID_H - 1 && cur_col == GRID_W - 1) begin
            res.frame_last = 1'b1;
            res.signature  = run_hash;
            if (run_hash == prev_sig) begin
                if (repeat_count != COUNT_MAX) begin
                    repeat_count++;
                end
            end else begin
                prev_sig        = run_hash;
                repeat_count    = 16'd1;
                res.sig_changed = 1'b1;
            end
            res.stable_count   = repeat_count;
            res.stable_reached = (repeat_count >= {8'd0, regs.stable_threshold});
            // one request per signature, re-armed only by a different stable signature
            if (res.stable_reached && (!requested || run_hash != requested_sig)) begin
                res.plan_request = 1'b1;
                requested_sig    = run_hash;
                requested        = 1'b1;
            end
            run_hash = HASH_BASIS;
            slot_idx = (slot_idx + 1) % SLOT_COUNT;
            if (frames_seen < SLOT_COUNT) begin
                frames_seen++;
            end
            cur_row = 0;
            cur_col = 0;
        end else if (cur_col == GRID_W - 1) begin
            cur_col = 0;
            cur_row++;
        end else begin
            cur_col++;
        end
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : track
        out_item_t want;
        int i;
        int j;

        if (!aresetn) begin
            for (i = 0; i < CELL_COUNT; i++) begin
                for (j = 0; j < SLOT_COUNT; j++) begin
                    history[i][j] = 8'd0;
                end
            end
            slot_idx      = 0;
            frames_seen   = 0;
            cur_row       = 0;
            cur_col       = 0;
            run_hash      = HASH_BASIS;
            prev_sig      = '0;
            requested_sig = '0;
            repeat_count  = '0;
            requested     = 1'b0;
            regs.stable_threshold = 8'd3;
            regs.marker_code      = 8'd64;
            regs.empty_code       = 8'd45;
            expected_cells.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_STABLE_THRESHOLD: regs.stable_threshold = cfg_wdata;
                    CFG_MARKER_CODE:      regs.marker_code      = cfg_wdata;
                    CFG_EMPTY_CODE:       regs.empty_code       = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_cells.push_back(filter_cell(s_data));
            end
            if (m_valid && m_ready) begin
                if (expected_cells.size() == 0) begin
                    fail_count++;
                    $display("%0t: result mismatch: expected none, actual %h", $time, m_data);
                end else begin
                    want = expected_cells.pop_front();
                    compare_field("filtered_cell", want.filtered_cell, m_data.filtered_cell);
                    compare_field("frame_last", want.frame_last, m_data.frame_last);
                    compare_field("signature", want.signature, m_data.signature);
                    compare_field("stable_count", want.stable_count, m_data.stable_count);
                    compare_field("sig_changed", want.sig_changed, m_data.sig_changed);
                    compare_field("stable_reached", want.stable_reached,
                                  m_data.stable_reached);
                    compare_field("plan_request", want.plan_request, m_data.plan_request);
                end
            end
        end
        queued = expected_cells.size();
    end

endmodule

/* verif/grid_majority_filter_signature_tb.sv */
// Testbench top for the grid majority filter: drives cell frames, register phases and
// random stalls, and gives the verdict from the checker's counts.
// Depends on gmfs_pkg, gmfs_frame_checker and the block itself.
`timescale 1ns / 1ps

module grid_majority_filter_signature_tb;
    import gmfs_pkg::*;

    localparam int CYCLE_LIMIT      = 50000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int PHASES           = 4;
    localparam int FRAMES_PER_PHASE = 1;
    localparam int DIRECTED_COUNT   = 18;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam logic [7:0] WALL_BYTE  = 8'h23;
    localparam logic [7:0] FLOOR_BYTE = 8'h2E;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [7:0]           cfg_wdata = '0;

    int mismatches;
    int pending;
    int cycles = 0;
    int src_gap_pct = 20;
    int snk_gap_pct = 20;
    int stall_left = 0;
    int frame_pos = 0;
    bit gaps_enabled = 1'b1;

    logic [7:0] base_map [CELL_COUNT];
    logic [7:0] marker_code_now = 8'd64;
    logic [7:0] empty_code_now = 8'd45;
    logic [7:0] frame_mcol;
    logic [7:0] frame_mrow;
    bit         noisy_frame = 1'b0;

    // opening cells of the first frame: origin marker, grid edges, off-grid
    // markers and stray marker bytes
    in_item_t directed_cells [DIRECTED_COUNT] = '{
        '{8'h00, 8'd0,   8'd0},
        '{8'hFF, 8'd255, 8'd255},
        '{8'h40, 8'd16,  8'd0},
        '{8'h40, 8'd3,   8'd12},
        '{8'hAA, 8'd4,   8'd0},
        '{8'h55, 8'd15,  8'd11},
        '{8'h2D, 8'd6,   8'd0},
        '{8'h80, 8'd7,   8'd1},
        '{8'h01, 8'd8,   8'd255},
        '{8'hFE, 8'd255, 8'd0},
        '{8'h7F, 8'd10,  8'd11},
        '{8'h40, 8'd11,  8'd0},
        '{8'h23, 8'd0,   8'd12},
        '{8'h2E, 8'd13,  8'd0},
        '{8'hC3, 8'd14,  8'd14},
        '{8'h3C, 8'd15,  8'd0},
        '{8'h96, 8'd0,   8'd1},
        '{8'h69, 8'd1,   8'd1}
    };

    grid_majority_filter_signature uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    gmfs_frame_checker frame_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Hold m_ready low for random stall bursts.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= (stall_left == 1);
        end else if ($urandom_range(0, 99) < snk_gap_pct) begin
            stall_left <= $urandom_range(1, 8);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic logic [7:0] palette_byte();
        case ($urandom_range(0, 5))
            0: return empty_code_now;
            1: return marker_code_now;
            2: return WALL_BYTE;
            3: return FLOOR_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int gap_level();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 5;
            2: return 20;
            default: return 50;
        endcase
    endfunction

    task automatic pick_marker();
        frame_mcol = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(GRID_W, 255))
                                                 : 8'($urandom_range(0, GRID_W - 1));
        frame_mrow = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(GRID_H, 255))
                                                 : 8'($urandom_range(0, GRID_H - 1));
    endtask

    // Mostly repeat the map so signatures settle; now and then edit a few cells
    // or send a noise frame.
    task automatic start_frame();
        int mode;

        mode = $urandom_range(0, 9);
        noisy_frame = (mode == 0);
        if (mode == 1 || mode == 2) begin
            repeat ($urandom_range(1, 3)) base_map[$urandom_range(0, CELL_COUNT - 1)] =
                palette_byte();
            if ($urandom_range(0, 1) == 1) begin
                pick_marker();
            end
        end
        if (gaps_enabled) begin
            src_gap_pct = gap_level();
            snk_gap_pct = gap_level();
        end
    endtask

    function automatic in_item_t frame_cell();
        in_item_t item;

        item.cell_in    = base_map[frame_pos];
        item.marker_col = frame_mcol;
        item.marker_row = frame_mrow;
        if (noisy_frame) begin
            if ($urandom_range(0, 1) == 1) begin
                item.cell_in = palette_byte();
            end
            case ($urandom_range(0, 7))
                0: begin
                    item.marker_col = 8'(frame_pos % GRID_W);
                    item.marker_row = 8'(frame_pos / GRID_W);
                end
                1, 2: begin
                    item.marker_col = 8'($urandom_range(0, 255));
                    item.marker_row = 8'($urandom_range(0, 255));
                end
                default: ;
            endcase
        end
        return item;
    endfunction

    task automatic send_cell(input in_item_t item);
        if ($urandom_range(0, 99) < src_gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        frame_pos = (frame_pos + 1) % CELL_COUNT;
    endtask

    task automatic wait_idle();
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [7:0] thr, input logic [7:0] mk,
                                input logic [7:0] em);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_STABLE_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge aclk);
        cfg_addr  <= CFG_MARKER_CODE;
        cfg_wdata <= mk;
        @(posedge aclk);
        cfg_addr  <= CFG_EMPTY_CODE;
        cfg_wdata <= em;
        @(posedge aclk);
        // unmapped index: the write must leave every register alone
        cfg_addr  <= CFG_IDX_SPARE;
        cfg_wdata <= 8'($urandom_range(0, 255));
        @(posedge aclk);
        cfg_we <= 1'b0;
        marker_code_now = mk;
        empty_code_now  = em;
    endtask

    initial begin
        int         phase;
        int         n;
        logic [7:0] thr;
        logic [7:0] mk;
        logic [7:0] em;

        for (n = 0; n < CELL_COUNT; n++) begin
            base_map[n] = palette_byte();
        end
        pick_marker();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (n = 0; n < DIRECTED_COUNT; n++) begin
            send_cell(directed_cells[n]);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            gaps_enabled = (phase < PHASES - 1);
            if (!gaps_enabled) begin
                src_gap_pct = 0;
                snk_gap_pct = 0;
            end
            if (phase > 0) begin
                s_valid <= 1'b0;
                wait_idle();
                case (phase)
                    1: begin thr = 8'd1;   mk = 8'd0;   em = 8'd255; end
                    2: begin thr = 8'd0;   mk = 8'd255; em = 8'd0;   end
                    3: begin
                        thr = 8'd255;
                        mk  = 8'($urandom_range(0, 255));
                        em  = 8'($urandom_range(0, 255));
                    end
                    default: begin thr = 8'd2; mk = 8'd64; em = 8'd64; end
                endcase
                program_regs(thr, mk, em);
            end
            for (n = 0; n < FRAMES_PER_PHASE * CELL_COUNT; n++) begin
                if (frame_pos == 0) begin
                    start_frame();
                end
                send_cell(frame_cell());
            end
        end

        s_valid <= 1'b0;
        wait_idle();
        if (mismatches == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
